>>> rtl/core/tli_pkg.sv
package tli_pkg;

  localparam int unsigned DataW        = 48;
  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned QueueDepth   = 4;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [2:0] KIND_EMPTY  = 3'd0;
  localparam logic [2:0] KIND_SINGLE = 3'd1;
  localparam logic [2:0] KIND_EXACT  = 3'd2;
  localparam logic [2:0] KIND_INTERP = 3'd3;
  localparam logic [2:0] KIND_EXT_LO = 3'd4;
  localparam logic [2:0] KIND_EXT_HI = 3'd5;
  localparam logic [2:0] KIND_ZERO_DX = 3'd6;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_QUERY
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
  } op_t;

endpackage

>>> rtl/core/table_linear_interpolator_unit.sv
// channel  dir  tdata                                   tuser
// s_       in   [47:0] x_value, [95:48] y_value         [1:0] command
// m_       out  [47:0] y_result                         [2:0] result_kind
//
// Clear and append are handled in the back end's idle state; unused commands
// are dropped at the front. None of these gives a result beat.
// Query: an empty table answers at once, a single point reads entry 0, else a
// binary search (one memory read per probe) ends in an exact hit or reads the
// bracketing pair; nonzero dx and offset add split multiply, serial divide.
// The restoring divider dominates. A 4-entry queue decouples input beats.
// rst_ni clears queue, point count and control; table contents undefined.
// Output register holds a result under stall; the back end waits behind it.
module table_linear_interpolator_unit
  import tli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [2*DataW-1:0]   s_tdata_i,   // x_value, y_value
  input  logic [1:0]           s_tuser_i,   // command
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [DataW-1:0]     m_tdata_o,   // y_result
  output logic [2:0]           m_tuser_o    // result_kind
);

  logic full, push, q_valid, pop;
  op_t  op_in, op_out;

  tli_front u_front (
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tuser_i  (s_tuser_i),
    .s_tdata_i  (s_tdata_i),
    .full_i     (full),
    .push_o     (push),
    .op_o       (op_in)
  );

  tli_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (op_out)
  );

  tli_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .op_i       (op_out),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule

>>> rtl/core/tli_front.sv
module tli_front
  import tli_pkg::*;
(
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [1:0]           s_tuser_i,
  input  logic [2*DataW-1:0]   s_tdata_i,
  input  logic                 full_i,
  output logic                 push_o,
  output op_t                  op_o
);

  logic keep;

  always_comb begin
    keep    = 1'b1;
    op_o.op = OP_QUERY;
    op_o.x  = s_tdata_i[DataW-1:0];
    op_o.y  = s_tdata_i[2*DataW-1:DataW];
    case (s_tuser_i)
      CMD_CLEAR:  op_o.op = OP_CLEAR;
      CMD_APPEND: op_o.op = OP_APPEND;
      CMD_QUERY:  op_o.op = OP_QUERY;
      default:    keep = 1'b0;
    endcase
  end

  // unused command code is consumed and dropped here
  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i && keep;

endmodule

>>> rtl/core/tli_queue.sv
module tli_queue
  import tli_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  op_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  op_t              mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;

  assign full_o  = cnt_q == (PtrW+1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign op_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

endmodule

>>> rtl/core/tli_back.sv
module tli_back
  import tli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  op_t                  op_i,
  output logic                 pop_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [DataW-1:0]     m_tdata_o,
  output logic [2:0]           m_tuser_o
);

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LW  = CW + 1;
  localparam int unsigned DW  = DataW + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned HW  = 25;
  localparam int unsigned QW  = 63;
  localparam int unsigned SW  = $clog2(PW);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SGL_W  = 5'd1;
  localparam logic [4:0] S_SGL    = 5'd2;
  localparam logic [4:0] S_BADDR  = 5'd3;
  localparam logic [4:0] S_BWAIT  = 5'd4;
  localparam logic [4:0] S_BCMP   = 5'd5;
  localparam logic [4:0] S_R0W    = 5'd6;
  localparam logic [4:0] S_R0     = 5'd7;
  localparam logic [4:0] S_R1W    = 5'd8;
  localparam logic [4:0] S_R1     = 5'd9;
  localparam logic [4:0] S_ABS    = 5'd10;
  localparam logic [4:0] S_MUL    = 5'd11;
  localparam logic [4:0] S_DIV    = 5'd12;
  localparam logic [4:0] S_RND    = 5'd13;
  localparam logic [4:0] S_SGN    = 5'd14;
  localparam logic [4:0] S_FIN    = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  localparam logic [63:0] QCap = 64'h4000_0000_0000_0000;
  localparam logic signed [64:0] YMax = 65'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [64:0] YMin = -65'sh0_0000_8000_0000_0000;

  logic signed [DataW-1:0] x_mem [TABLE_DEPTH];
  logic signed [DataW-1:0] y_mem [TABLE_DEPTH];

  logic [4:0]              state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic signed [DataW-1:0] x_q, x_d;
  logic signed [LW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]           mid_q, mid_d, i1_q, i1_d, rd_addr_q, rd_addr_d;
  logic [2:0]              kind_q, kind_d;
  logic signed [DataW-1:0] x0_q, x0_d, y0_q, y0_d;
  logic signed [DataW-1:0] rd_x_q, rd_y_q;
  logic signed [DW-1:0]    dx_q, dx_d, dy_q, dy_d, off_q, off_d;
  logic [DW-1:0]           a_q, a_d, b_q, b_d, c_q, c_d;
  logic                    neg_q, neg_d, big_q, big_d;
  logic [PW-1:0]           acc_q, acc_d;
  logic [SW-1:0]           step_q, step_d;
  logic [DW-1:0]           r_q, r_d;
  logic [QW-1:0]           qt_q, qt_d;
  logic [63:0]             qr_q, qr_d;
  logic signed [63:0]      sq_q, sq_d;
  logic signed [DataW-1:0] res_y_q, res_y_d;
  logic [2:0]              res_kind_q, res_kind_d;
  logic                    out_valid_q, out_valid_d;
  logic [DataW-1:0]        out_y_q, out_y_d;
  logic [2:0]              out_kind_q, out_kind_d;

  logic                    we;
  logic [LW:0]             mid_sum;
  logic [HW-1:0]           pa, pb;
  logic [2*HW-1:0]         pp;
  logic [DW:0]             rs;
  logic [DW:0]             rn;
  logic                    take;
  logic [63:0]             capped;
  logic signed [64:0]      sum;

  assign pop_o      = valid_i && (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_y_q;
  assign m_tuser_o  = out_kind_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    x_d        = x_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    i1_d       = i1_q;
    rd_addr_d  = rd_addr_q;
    kind_d     = kind_q;
    x0_d       = x0_q;
    y0_d       = y0_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    off_d      = off_q;
    a_d        = a_q;
    b_d        = b_q;
    c_d        = c_q;
    neg_d      = neg_q;
    big_d      = big_q;
    acc_d      = acc_q;
    step_d     = step_q;
    r_d        = r_q;
    qt_d       = qt_q;
    qr_d       = qr_q;
    sq_d       = sq_q;
    res_y_d    = res_y_q;
    res_kind_d = res_kind_q;
    out_valid_d = out_valid_q;
    out_y_d    = out_y_q;
    out_kind_d = out_kind_q;
    we         = 1'b0;
    mid_sum    = {lo_q[LW-1], lo_q} + {hi_q[LW-1], hi_q};
    pa         = step_q[0] ? HW'(a_q[DW-1:HW]) : a_q[HW-1:0];
    pb         = step_q[1] ? HW'(b_q[DW-1:HW]) : b_q[HW-1:0];
    pp         = pa * pb;
    rs         = {r_q, acc_q[PW-1]};
    rn         = rs - {1'b0, c_q};
    take       = rs >= {1'b0, c_q};
    capped     = (big_q || qr_q > QCap) ? QCap : qr_q;
    sum        = {y0_q[DataW-1], {(65-DataW){y0_q[DataW-1]}}, y0_q[DataW-2:0]} +
                 {sq_q[63], sq_q};

    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          case (op_i.op)
            OP_CLEAR: cnt_d = '0;
            OP_APPEND: begin
              if (cnt_q < CW'(TABLE_DEPTH)) begin
                we    = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end
            end
            OP_QUERY: begin
              x_d = op_i.x;
              if (cnt_q == '0) begin
                res_y_d    = '0;
                res_kind_d = KIND_EMPTY;
                state_d    = S_DONE;
              end else if (cnt_q == CW'(1)) begin
                rd_addr_d = '0;
                state_d   = S_SGL_W;
              end else begin
                lo_d    = '0;
                hi_d    = $signed(LW'(cnt_q)) - $signed(LW'(1));
                state_d = S_BADDR;
              end
            end
            default: ;
          endcase
        end
      end
      S_SGL_W: state_d = S_SGL;
      S_SGL: begin
        res_y_d    = rd_y_q;
        res_kind_d = KIND_SINGLE;
        state_d    = S_DONE;
      end
      S_BADDR: begin
        if (hi_q >= lo_q) begin
          mid_d     = mid_sum[AW:1];
          rd_addr_d = mid_sum[AW:1];
          state_d   = S_BWAIT;
        end else begin
          if (lo_q >= $signed(LW'(cnt_q))) begin
            rd_addr_d = AW'(cnt_q - CW'(2));
            i1_d      = AW'(cnt_q - CW'(1));
            kind_d    = KIND_EXT_HI;
          end else if (hi_q[LW-1]) begin
            rd_addr_d = '0;
            i1_d      = AW'(1);
            kind_d    = KIND_EXT_LO;
          end else begin
            rd_addr_d = hi_q[AW-1:0];
            i1_d      = lo_q[AW-1:0];
            kind_d    = KIND_INTERP;
          end
          state_d = S_R0W;
        end
      end
      S_BWAIT: state_d = S_BCMP;
      S_BCMP: begin
        if (x_q < rd_x_q) begin
          hi_d    = $signed(LW'(mid_q)) - $signed(LW'(1));
          state_d = S_BADDR;
        end else if (x_q > rd_x_q) begin
          lo_d    = $signed(LW'(mid_q)) + $signed(LW'(1));
          state_d = S_BADDR;
        end else begin
          res_y_d    = rd_y_q;
          res_kind_d = KIND_EXACT;
          state_d    = S_DONE;
        end
      end
      S_R0W: state_d = S_R0;
      S_R0: begin
        x0_d      = rd_x_q;
        y0_d      = rd_y_q;
        rd_addr_d = i1_q;
        state_d   = S_R1W;
      end
      S_R1W: state_d = S_R1;
      S_R1: begin
        dx_d    = {rd_x_q[DataW-1], rd_x_q} - {x0_q[DataW-1], x0_q};
        dy_d    = {rd_y_q[DataW-1], rd_y_q} - {y0_q[DataW-1], y0_q};
        off_d   = {x_q[DataW-1], x_q} - {x0_q[DataW-1], x0_q};
        state_d = S_ABS;
      end
      S_ABS: begin
        if (dx_q == '0) begin
          res_y_d    = y0_q;
          res_kind_d = KIND_ZERO_DX;
          state_d    = S_DONE;
        end else if (off_q == '0) begin
          res_y_d    = y0_q;
          res_kind_d = kind_q;
          state_d    = S_DONE;
        end else begin
          a_d     = off_q[DW-1] ? DW'(-off_q) : DW'(off_q);
          b_d     = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
          c_d     = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
          neg_d   = off_q[DW-1] ^ dy_q[DW-1] ^ dx_q[DW-1];
          acc_d   = '0;
          step_d  = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        acc_d = acc_q + (PW'(pp) << (HW * (32'(step_q[0]) + 32'(step_q[1]))));
        if (step_q == SW'(3)) begin
          step_d  = '0;
          r_d     = '0;
          qt_d    = '0;
          big_d   = 1'b0;
          state_d = S_DIV;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DIV: begin
        // quotient bit index is PW-1-step; bits at or above QW only flag overflow
        acc_d = acc_q << 1;
        r_d   = take ? rn[DW-1:0] : rs[DW-1:0];
        if (step_q < SW'(PW - QW)) begin
          big_d = big_q | take;
        end else begin
          qt_d = {qt_q[QW-2:0], take};
        end
        if (step_q == SW'(PW - 1)) begin
          state_d = S_RND;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_RND: begin
        qr_d    = 64'(qt_q) + 64'(!big_q && (r_q >= c_q - r_q));
        state_d = S_SGN;
      end
      S_SGN: begin
        sq_d    = neg_q ? -$signed(capped) : $signed(capped);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (sum > YMax) begin
          res_y_d = YMax[DataW-1:0];
        end else if (sum < YMin) begin
          res_y_d = YMin[DataW-1:0];
        end else begin
          res_y_d = sum[DataW-1:0];
        end
        res_kind_d = kind_q;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          out_valid_d = 1'b1;
          out_y_d     = res_y_q;
          out_kind_d  = res_kind_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    i1_q       <= i1_d;
    rd_addr_q  <= rd_addr_d;
    kind_q     <= kind_d;
    x0_q       <= x0_d;
    y0_q       <= y0_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    off_q      <= off_d;
    a_q        <= a_d;
    b_q        <= b_d;
    c_q        <= c_d;
    neg_q      <= neg_d;
    big_q      <= big_d;
    acc_q      <= acc_d;
    step_q     <= step_d;
    r_q        <= r_d;
    qt_q       <= qt_d;
    qr_q       <= qr_d;
    sq_q       <= sq_d;
    res_y_q    <= res_y_d;
    res_kind_q <= res_kind_d;
    out_y_q    <= out_y_d;
    out_kind_q <= out_kind_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      x_mem[cnt_q[AW-1:0]] <= op_i.x;
      y_mem[cnt_q[AW-1:0]] <= op_i.y;
    end
    rd_x_q <= x_mem[rd_addr_q];
    rd_y_q <= y_mem[rd_addr_q];
  end

endmodule

>>> rtl/core/tli_checker.sv
module tli_checker
  import tli_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_tvalid_i,
  input logic                 s_tready_o,
  input logic [1:0]           s_tuser_i,
  input logic                 m_tvalid_o,
  input logic                 m_tready_i,
  input logic [DataW-1:0]     m_tdata_o,
  input logic [2:0]           m_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("result beat dropped or changed under stall");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tuser_o <= KIND_ZERO_DX)
    else $error("undefined result kind");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o == KIND_EMPTY |-> m_tdata_o == '0)
    else $error("empty table result not zero");

endmodule

bind table_linear_interpolator_unit tli_checker u_tli_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .s_tuser_i  (s_tuser_i),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);

>>> sim/table_linear_interpolator_unit_tb.sv
module table_linear_interpolator_unit_tb;
  import tli_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = DefTableDepth;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam longint YMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint YMin = -64'sh0000_8000_0000_0000;
  localparam longint CycleLimit = 3000000;
  localparam int RandomItems = 1950;

  typedef struct {
    logic [DataW-1:0] y;
    logic [2:0]       kind;
  } answer_t;

  typedef struct {
    bit      typed;
    answer_t ans;
  } pinned_t;

  typedef struct {
    logic [1:0] cmd;
    longint     x;
    longint     y;
    bit         typed;
    longint     ey;
    logic [2:0] ek;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_tvalid_i;
  logic               s_tready_o;
  logic [2*DataW-1:0] s_tdata_i;
  logic [1:0]         s_tuser_i;
  logic               m_tvalid_o;
  logic               m_tready_i;
  logic [DataW-1:0]   m_tdata_o;
  logic [2:0]         m_tuser_o;

  table_linear_interpolator_unit u_dut (.*);

  longint     tbl_x [Depth];
  longint     tbl_y [Depth];
  int         n_points;
  answer_t    answers_q [$];
  pinned_t    pinned_q [$];
  int         errors;
  longint     cycles;
  int         items_sent;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("table_linear_interpolator_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic report_err(string what, longint got, longint want);
    $display("ERROR t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // round(off*dy/dx), ties away from zero, magnitude capped at 2^62
  function automatic longint slope_term(longint off, longint dy, longint dx);
    logic [63:0]  a, b, c, q;
    logic [127:0] p, qf, rm;
    bit           neg, big;
    neg = (off < 0) ^ (dy < 0) ^ (dx < 0);
    a = (off < 0) ? -off : off;
    b = (dy < 0) ? -dy : dy;
    c = (dx < 0) ? -dx : dx;
    p = {64'd0, a} * {64'd0, b};
    qf = p / {64'd0, c};
    rm = p % {64'd0, c};
    big = (qf[127:63] != '0);
    q = qf[63:0];
    if (!big && rm >= ({64'd0, c} - rm)) q = q + 1;
    if (big || q > 64'h4000_0000_0000_0000) q = 64'h4000_0000_0000_0000;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic answer_t lookup(longint x);
    answer_t r;
    int      lo, hi, mid, i0, i1;
    longint  v;
    lo = 0;
    hi = n_points - 1;
    if (n_points == 0) begin
      r.y = '0; r.kind = KIND_EMPTY; return r;
    end
    if (n_points == 1) begin
      r.y = tbl_y[0][DataW-1:0]; r.kind = KIND_SINGLE; return r;
    end
    while (hi >= lo) begin
      mid = (lo + hi) >> 1;
      if (x < tbl_x[mid]) hi = mid - 1;
      else if (x > tbl_x[mid]) lo = mid + 1;
      else begin
        r.y = tbl_y[mid][DataW-1:0]; r.kind = KIND_EXACT; return r;
      end
    end
    if (lo >= n_points) begin
      i1 = n_points - 1; i0 = n_points - 2; r.kind = KIND_EXT_HI;
    end else if (hi < 0) begin
      i0 = 0; i1 = 1; r.kind = KIND_EXT_LO;
    end else begin
      i0 = hi; i1 = lo; r.kind = KIND_INTERP;
    end
    if (tbl_x[i1] == tbl_x[i0]) begin
      r.y = tbl_y[i0][DataW-1:0]; r.kind = KIND_ZERO_DX; return r;
    end
    if (x == tbl_x[i0]) begin
      r.y = tbl_y[i0][DataW-1:0]; return r;
    end
    v = tbl_y[i0] + slope_term(x - tbl_x[i0], tbl_y[i1] - tbl_y[i0], tbl_x[i1] - tbl_x[i0]);
    if (v > YMax) v = YMax;
    if (v < YMin) v = YMin;
    r.y = v[DataW-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    answer_t got, want;
    pinned_t pin;
    longint  xs, ys;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        if (answers_q.size() == 0) begin
          report_err("unexpected result beat", longint'($signed(m_tdata_o)), 0);
        end else begin
          want = answers_q.pop_front();
          if (m_tdata_o !== want.y)
            report_err("y_result", longint'($signed(m_tdata_o)), longint'($signed(want.y)));
          if (m_tuser_o !== want.kind)
            report_err("result_kind", longint'(m_tuser_o), longint'(want.kind));
        end
      end
      if (s_tvalid_i && s_tready_o) begin
        xs = longint'($signed(s_tdata_i[DataW-1:0]));
        ys = longint'($signed(s_tdata_i[2*DataW-1:DataW]));
        case (s_tuser_i)
          CMD_CLEAR: n_points = 0;
          CMD_APPEND: begin
            if (n_points < Depth) begin
              tbl_x[n_points] = xs;
              tbl_y[n_points] = ys;
              n_points++;
            end
          end
          CMD_QUERY: begin
            pin = pinned_q.pop_front();
            got = lookup(xs);
            answers_q.push_back(pin.typed ? pin.ans : got);
          end
          default: ;
        endcase
      end
    end
  end

  initial begin
    m_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        m_tready_i <= 1'b0;
        repeat (hold_req) @(negedge clk_i);
        hold_req = 0;
      end
      m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send(logic [1:0] cmd, longint x, longint y,
                      bit typed = 0, longint ey = 0, logic [2:0] ek = KIND_EMPTY);
    pinned_t pin;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    if (cmd == CMD_QUERY) begin
      pin.typed = typed;
      pin.ans.y = ey[DataW-1:0];
      pin.ans.kind = ek;
      pinned_q.push_back(pin);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i <= cmd;
    s_tdata_i <= {y[DataW-1:0], x[DataW-1:0]};
    do @(posedge clk_i); while (!s_tready_o);
    // tvalid is dropped or replaced by the next call at this falling edge
    @(negedge clk_i);
    items_sent++;
    if (items_sent < RandomItems / 3) begin
      send_idle_pct = 23; recv_idle_pct = 60;
    end else if (items_sent < 2 * RandomItems / 3) begin
      send_idle_pct = 60; recv_idle_pct = 23;
    end else begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
  endtask

  function automatic longint rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return YMin;
      1: return YMax;
      2, 3, 4: return longint'($signed(r[DataW-1:0]));
      default: return longint'($signed(r[25:0]));
    endcase
  endfunction

  task automatic drain();
    s_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (answers_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic session(int npts, int nq, bit sorted);
    longint xs [$];
    longint qx;
    int     k;
    send(CMD_CLEAR, rand48(), rand48());
    for (int i = 0; i < npts; i++) begin
      if (i > 0 && $urandom_range(15) == 0) xs.push_back(xs[i-1]);
      else xs.push_back(rand48());
    end
    if (sorted) xs.sort();
    foreach (xs[i]) begin
      send(CMD_APPEND, xs[i], rand48());
      if ($urandom_range(20) == 0) send(CMD_UNUSED, rand48(), rand48());
    end
    for (int i = 0; i < nq; i++) begin
      k = (npts > 0) ? $urandom_range(npts - 1) : 0;
      case ($urandom_range(5))
        0: qx = (npts > 0) ? xs[k] : rand48();
        1: qx = (npts > 1 && k + 1 < npts) ? xs[k] + (xs[k+1] - xs[k]) / 2 : rand48();
        2: qx = (npts > 0) ? xs[k] + $urandom_range(3) - 1 : rand48();
        default: qx = rand48();
      endcase
      if (qx > YMax) qx = YMax;
      if (qx < YMin) qx = YMin;
      send(CMD_QUERY, qx, rand48());
      if ($urandom_range(30) == 0) send(CMD_UNUSED, rand48(), rand48());
    end
  endtask

  row_t rows [$];

  initial begin
    longint one;
    one = 64'sd65536;
    errors = 0; cycles = 0; items_sent = 0; n_points = 0; hold_req = 0;
    send_idle_pct = 23; recv_idle_pct = 60;
    rst_ni = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i = '0;
    s_tuser_i = CMD_CLEAR;

    rows = '{
      '{CMD_QUERY,  123,         0,          1, 0,          KIND_EMPTY},
      '{CMD_APPEND, 0,           5 * one,    0, 0,          KIND_EMPTY},
      '{CMD_QUERY,  777,         0,          1, 5 * one,    KIND_SINGLE},
      '{CMD_APPEND, 10 * one,    25 * one,   0, 0,          KIND_EMPTY},
      '{CMD_APPEND, 20 * one,    -15 * one,  0, 0,          KIND_EMPTY},
      '{CMD_QUERY,  10 * one,    0,          1, 25 * one,   KIND_EXACT},
      '{CMD_QUERY,  5 * one,     0,          0, 0,          KIND_EMPTY},
      '{CMD_QUERY,  -4 * one,    0,          0, 0,          KIND_EMPTY},
      '{CMD_QUERY,  30 * one,    0,          0, 0,          KIND_EMPTY},
      '{CMD_APPEND, 20 * one,    7,          0, 0,          KIND_EMPTY},
      '{CMD_QUERY,  25 * one,    0,          1, -15 * one,  KIND_ZERO_DX},
      '{CMD_UNUSED, 3 * one,     -1,         0, 0,          KIND_EMPTY},
      '{CMD_QUERY,  15 * one,    0,          0, 0,          KIND_EMPTY},
      '{CMD_CLEAR,  0,           0,          0, 0,          KIND_EMPTY},
      '{CMD_QUERY,  0,           -1,         1, 0,          KIND_EMPTY},
      '{CMD_APPEND, YMin,        YMax,       0, 0,          KIND_EMPTY},
      '{CMD_APPEND, YMax,        YMin,       0, 0,          KIND_EMPTY},
      '{CMD_QUERY,  0,           0,          0, 0,          KIND_EMPTY},
      '{CMD_QUERY,  YMin,        0,          1, YMax,       KIND_EXACT},
      '{CMD_QUERY,  YMax,        0,          1, YMin,       KIND_EXACT},
      '{CMD_CLEAR,  0,           0,          0, 0,          KIND_EMPTY},
      '{CMD_APPEND, 0,           YMax,       0, 0,          KIND_EMPTY},
      '{CMD_APPEND, 1,           YMin,       0, 0,          KIND_EMPTY},
      '{CMD_QUERY,  YMax,        0,          0, 0,          KIND_EMPTY},
      '{CMD_QUERY,  YMin,        0,          0, 0,          KIND_EMPTY}
    };

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i])
      send(rows[i].cmd, rows[i].x, rows[i].y, rows[i].typed, rows[i].ey, rows[i].ek);

    items_sent = 0;
    while (items_sent < RandomItems) begin
      if (items_sent > 300 && items_sent < 340) begin
        hold_req = 3000;
        session(12, 20, 1);
      end else if (items_sent > 700 && items_sent < 760) begin
        drain();
        session(Depth + 3, 12, 1);
      end else if ($urandom_range(9) == 0) begin
        session($urandom_range(0, 10), $urandom_range(1, 6), 0);
      end else if ($urandom_range(9) == 0) begin
        session($urandom_range(13, 64), $urandom_range(2, 10), 1);
      end else begin
        session($urandom_range(0, 12), $urandom_range(1, 8), 1);
      end
    end

    drain();
    repeat (300) @(negedge clk_i);
    if (errors == 0) begin
      $display("table_linear_interpolator_unit_tb: done, clean");
    end else begin
      $display("table_linear_interpolator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
